FILE: design/aesd_pkg.sv
// Shared types, constants and GF(2^8) helpers for the AES-128 block decryptor.
// Holds the inverse S-box table and the InvMixColumns / InvShiftRows+InvSubBytes
// functions used by aesd_round; the top level and bench use the types and constants. No dependencies.
package aesd_pkg;

   localparam int ROUNDS   = 10;
   localparam int KEY_ROWS = ROUNDS + 1;
   localparam int RND_W    = $clog2(KEY_ROWS);
   localparam int KR_W     = 4;

   localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS);
   localparam logic [KR_W-1:0]  KR_MAX   = KR_W'(ROUNDS);

   localparam logic KIND_KEY   = 1'b0;
   localparam logic KIND_BLOCK = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } aesd_state_type;

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
      8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
      8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
      8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
      8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
      8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
      8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
      8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
      8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
      8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
      8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
      8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
      8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
      8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
      8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
      8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
      8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
      8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
      8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
      8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
      8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
      8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
      8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
      8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
      8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
      8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
      8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
      8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
      8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
      8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
      8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
      8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
   };

   function automatic logic [7:0] gf_xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // One column, byte 0 (row 0) in the top bits.
   function automatic logic [31:0] inv_mix_col(input logic [31:0] col);
      logic [7:0] a  [4];
      logic [7:0] m9 [4];
      logic [7:0] m11[4];
      logic [7:0] m13[4];
      logic [7:0] m14[4];
      logic [7:0] x2, x4, x8;
      for (int i = 0; i < 4; i++) begin
         a[i]   = col[31-8*i -: 8];
         x2     = gf_xtime(a[i]);
         x4     = gf_xtime(x2);
         x8     = gf_xtime(x4);
         m9[i]  = x8 ^ a[i];
         m11[i] = x8 ^ x2 ^ a[i];
         m13[i] = x8 ^ x4 ^ a[i];
         m14[i] = x8 ^ x4 ^ x2;
      end
      return {m14[0] ^ m11[1] ^ m13[2] ^ m9[3],
              m9[0]  ^ m14[1] ^ m11[2] ^ m13[3],
              m13[0] ^ m9[1]  ^ m14[2] ^ m11[3],
              m11[0] ^ m13[1] ^ m9[2]  ^ m14[3]};
   endfunction

   function automatic logic [127:0] inv_mix(input logic [127:0] s);
      logic [127:0] t;
      for (int c = 0; c < 4; c++) begin
         t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
      end
      return t;
   endfunction

   // State byte (row r, column c) is byte 4c+r, byte 0 at the top.
   function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
      logic [127:0] t;
      int src;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            src = 4 * ((c - r) & 3) + r;
            t[127-8*(4*c+r) -: 8] = INV_SBOX[s[127-8*src -: 8]];
         end
      end
      return t;
   endfunction

endpackage

FILE: design/aesd_round.sv
// One inverse AES round: AddRoundKey, optional InvMixColumns, then
// InvShiftRows and InvSubBytes. Uses aesd_pkg.
module aesd_round (
   input  logic [127:0] state_i,
   input  logic [127:0] key_i,
   input  logic         mix_en,
   output logic [127:0] state_o
);
   import aesd_pkg::*;

   logic [127:0] keyed;
   logic [127:0] mixed;

   assign keyed   = state_i ^ key_i;
   assign mixed   = mix_en ? inv_mix(keyed) : keyed;
   assign state_o = inv_shift_sub(mixed);

endmodule

FILE: design/aes128_block_decrypt_top.sv
// AES-128 inverse cipher with an external round-key store.
// Key-load beat: written to the key store, no result. Block beat: the round unit
// runs one round per cycle with one key row read per round, then a final key
// addition loads the output register; no new beat is taken until that load,
// which waits while rsp_stall holds the output register.
// Reset clears the sequencer and output valid; the key store is not cleared.
module aes128_block_decrypt_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [3:0]  req_key_round,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_text_high,
   output logic [63:0] rsp_text_low
);
   import aesd_pkg::*;

   // Sequencer
   aesd_state_type   state_ff, state_in;
   logic [RND_W-1:0] rnd_ff, rnd_in;

   // Working block and the round key for rnd_ff
   logic [127:0]     blk_ff, blk_in;
   logic [127:0]     key_q_ff;
   logic [127:0]     round_out;

   // Key store: one 128-bit row per round key
   logic [127:0]     key_mem [KEY_ROWS];
   logic             key_we;

   // Output register
   logic             out_valid_ff, out_valid_in;
   logic             out_load;
   logic [127:0]     text_ff;

   // The shared round unit; the first round after acceptance skips InvMixColumns.
   aesd_round u_round (
      .state_i (blk_ff),
      .key_i   (key_q_ff),
      .mix_en  (rnd_ff != RND_LAST),
      .state_o (round_out)
   );

   // Hold off new beats while a block is in the rounds or waiting for the output register.
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rnd_in       = rnd_ff;
      blk_in       = blk_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_load     = 1'b0;
      key_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_kind == KIND_BLOCK) begin
                  // Start with the last round key.
                  state_in = ST_RUN;
                  rnd_in   = RND_LAST;
                  blk_in   = {req_data_high, req_data_low};
               end else if (req_key_round <= KR_MAX) begin
                  // Drop key loads past the last round.
                  key_we = 1'b1;
               end
            end
         end
         ST_RUN: begin
            if (rnd_ff != '0) begin
               // Advance one round.
               blk_in = round_out;
               rnd_in = rnd_ff - 1'b1;
            end else if (!out_valid_ff || !rsp_stall) begin
               // Final key addition straight into a free output register.
               out_load     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rnd_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rnd_ff       <= rnd_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      if (out_load) begin
         text_ff <= blk_ff ^ key_q_ff;
      end
   end

   // Key store: write on a key-load beat, read the row for the next round.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[req_key_round[RND_W-1:0]] <= {req_data_high, req_data_low};
      end
      key_q_ff <= key_mem[rnd_in];
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_text_high = text_ff[127:64];
   assign rsp_text_low  = text_ff[63:0];

   // Round counter never leaves the key range while busy.
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (rnd_ff <= RND_LAST))
      else $error("round counter out of range");

   // A result appears only after the final round.
   a_out_source: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_RUN && rnd_ff == '0))
      else $error("result without final round");

   // An accepted block starts at the last round key.
   a_block_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_BLOCK)
      |=> (state_ff == ST_RUN && rnd_ff == RND_LAST))
      else $error("block did not start at the last round");

   // A key-load beat never starts the rounds.
   a_key_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_kind == KIND_KEY) |=> (state_ff == ST_IDLE))
      else $error("key load left idle");

endmodule

FILE: tb/sv/aes128_block_decrypt_top_tb.sv
// Self-checking bench for aes128_block_decrypt_top: round-key loads and block decryption.
// Depends on aesd_pkg (kind codes, ROUNDS, KR_MAX) and the DUT; the expected plaintext
// comes from a bench-side AES inverse cipher with its own GF(2^8) arithmetic.
module aes128_block_decrypt_top_tb;
   import aesd_pkg::*;

   localparam int QUIET_LIMIT = 2000;   // cycles with no beat moving on either channel
   localparam int DRAIN_TAIL  = 30;     // margin for a last result to surface
   localparam int PRINT_CAP   = 100;

   typedef struct packed {
      logic        kind;
      logic [3:0]  key_round;
      logic [63:0] data_high;
      logic [63:0] data_low;
   } req_beat_type;

   typedef struct packed {
      logic [63:0] text_high;
      logic [63:0] text_low;
   } plain_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_kind      = KIND_KEY;
   logic [3:0]  req_key_round = '0;
   logic [63:0] req_data_high = '0;
   logic [63:0] req_data_low  = '0;
   logic        rsp_stall     = 1'b0;
   logic        req_stall;
   logic        rsp_valid;
   logic [63:0] rsp_text_high;
   logic [63:0] rsp_text_low;

   // Stimulus and expectation stores.
   req_beat_type pending_beats[$];
   plain_type    plain_due[$];

   // Bench copy of the round-key store and the inverse S-box built at time 0.
   logic [127:0] key_rows [0:ROUNDS];
   logic [7:0]   unsub_tab [256];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int beats_queued   = 0;
   int beats_taken    = 0;
   int fail_count     = 0;
   int quiet_cycles   = 0;
   logic req_took     = 1'b0;

   aes128_block_decrypt_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_key_round (req_key_round),
      .req_data_high (req_data_high),
      .req_data_low  (req_data_low),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_text_high (rsp_text_high),
      .rsp_text_low  (rsp_text_low)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // GF(2^8) arithmetic, reduction polynomial x^8 + x^4 + x^3 + x + 1
   // ---------------------------------------------------------------------
   function automatic logic [7:0] gf_dbl(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Shift-and-add product.
   function automatic logic [7:0] gf_prod(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc ^= a;
         a = gf_dbl(a);
      end
      return acc;
   endfunction

   // Inverse as a^254 by repeated squaring; zero maps to zero.
   function automatic logic [7:0] gf_recip(input logic [7:0] a);
      logic [7:0] p, r;
      p = a;
      r = 8'h01;
      for (int i = 0; i < 7; i++) begin
         p = gf_prod(p, p);
         r = gf_prod(r, p);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Inverse cipher on the bench key store. State byte (row r, column c)
   // is byte 4c+r, byte 0 in the top bits of the high word.
   // ---------------------------------------------------------------------
   function automatic plain_type decrypt_block(input logic [63:0] hi, input logic [63:0] lo);
      logic [127:0] blk;
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a [4];
      int           rnd;
      blk = {hi, lo} ^ key_rows[ROUNDS];
      for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
      for (rnd = ROUNDS - 1; rnd >= 0; rnd--) begin
         // InvShiftRows and InvSubBytes: row r rotates right by r columns.
         for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) t[4*c+r] = unsub_tab[s[4*((c - r + 4) % 4) + r]];
         end
         for (int i = 0; i < 16; i++) s[i] = t[i] ^ key_rows[rnd][127-8*i -: 8];
         // InvMixColumns on every round but the last key addition.
         if (rnd > 0) begin
            for (int c = 0; c < 4; c++) begin
               for (int r = 0; r < 4; r++) a[r] = s[4*c+r];
               s[4*c]   = gf_prod(a[0], 8'd14) ^ gf_prod(a[1], 8'd11)
                        ^ gf_prod(a[2], 8'd13) ^ gf_prod(a[3], 8'd9);
               s[4*c+1] = gf_prod(a[0], 8'd9)  ^ gf_prod(a[1], 8'd14)
                        ^ gf_prod(a[2], 8'd11) ^ gf_prod(a[3], 8'd13);
               s[4*c+2] = gf_prod(a[0], 8'd13) ^ gf_prod(a[1], 8'd9)
                        ^ gf_prod(a[2], 8'd14) ^ gf_prod(a[3], 8'd11);
               s[4*c+3] = gf_prod(a[0], 8'd11) ^ gf_prod(a[1], 8'd13)
                        ^ gf_prod(a[2], 8'd9)  ^ gf_prod(a[3], 8'd14);
            end
         end
      end
      for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
      return plain_type'(blk);
   endfunction

   // Apply one accepted beat: a key load updates the store (rounds above
   // ROUNDS are dropped), a block queues its plaintext.
   function automatic void absorb_beat(input req_beat_type b);
      if (b.kind == KIND_KEY) begin
         if (b.key_round <= KR_MAX) key_rows[b.key_round] = {b.data_high, b.data_low};
      end else begin
         plain_due.push_back(decrypt_block(b.data_high, b.data_low));
      end
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
   endtask

   // ---------------------------------------------------------------------
   // Driver: change inputs on the falling edge. Hold a beat until the DUT
   // takes it, then advance to the next one or drop valid.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin : drive_req
      req_beat_type nb;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nb = pending_beats.pop_front();
            req_valid     <= 1'b1;
            req_kind      <= nb.kind;
            req_key_round <= nb.key_round;
            req_data_high <= nb.data_high;
            req_data_low  <= nb.data_low;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // ---------------------------------------------------------------------
   // Monitor: sample on the rising edge. Check a delivered result first,
   // then fold in the beat accepted on the same edge.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : watch_dut
      plain_type want;
      req_beat_type got;
      req_took <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (plain_due.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h_%h",
                                         rsp_text_high, rsp_text_low));
            end else begin
               want = plain_due.pop_front();
               if (rsp_text_high !== want.text_high)
                  report_mismatch($sformatf("text_high %h, want %h",
                                            rsp_text_high, want.text_high));
               if (rsp_text_low !== want.text_low)
                  report_mismatch($sformatf("text_low %h, want %h",
                                            rsp_text_low, want.text_low));
            end
         end
         if (req_valid && !req_stall) begin
            got = req_beat_type'{req_kind, req_key_round, req_data_high, req_data_low};
            absorb_beat(got);
            beats_taken++;
         end
      end
   end

   // Watchdog: end the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic put_beat(input logic kind, input logic [3:0] kr,
                           input logic [63:0] hi, input logic [63:0] lo);
      pending_beats.push_back(req_beat_type'{kind, kr, hi, lo});
      beats_queued++;
   endtask

   // Mostly random words, with the all-zero and all-one extremes mixed in.
   function automatic logic [63:0] rand_word();
      case ($urandom_range(15))
         0:       return 64'h0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Mix of blocks and key reloads; loads to rounds past ROUNDS are dropped by
   // the DUT and do not count toward n.
   task automatic queue_random(input int n);
      int made, roll;
      made = 0;
      while (made < n) begin
         roll = $urandom_range(99);
         if (roll < 6) begin
            put_beat(KIND_KEY, 4'($urandom_range(15, ROUNDS + 1)), rand_word(), rand_word());
         end else if (roll < 30) begin
            put_beat(KIND_KEY, 4'($urandom_range(ROUNDS)), rand_word(), rand_word());
            made++;
         end else begin
            put_beat(KIND_BLOCK, 4'($urandom_range(15)), rand_word(), rand_word());
            made++;
         end
      end
   endtask

   // Hold the sender until every queued beat is taken and every result is in.
   task automatic wait_drained();
      while (beats_taken != beats_queued || plain_due.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      logic [7:0] v, y;
      // Inverse S-box: inverse affine map, then field inverse.
      for (int x = 0; x < 256; x++) begin
         v = 8'(x);
         y = {v[6:0], v[7]} ^ {v[4:0], v[7:5]} ^ {v[1:0], v[7:2]} ^ 8'h05;
         unsub_tab[x] = gf_recip(y);
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Phase 1: light sender gaps, heavy receiver stalls.
      send_idle_pct  = 8;
      recv_stall_pct = 65;

      // Load every round key before the first block; the store is undefined
      // until written. Key 0 all zeros, last key all ones.
      put_beat(KIND_KEY, 4'd0, 64'h0, 64'h0);
      for (int k = 1; k < ROUNDS; k++)
         put_beat(KIND_KEY, 4'(k), {$urandom, $urandom}, {$urandom, $urandom});
      put_beat(KIND_KEY, KR_MAX, '1, '1);

      // Round numbers past the last key: must leave the store untouched.
      put_beat(KIND_KEY, KR_MAX + 4'd1, 64'h0123456789abcdef, 64'hfedcba9876543210);
      put_beat(KIND_KEY, 4'hf, '1, '1);

      // Blocks at the field extremes and a few fixed patterns.
      put_beat(KIND_BLOCK, 4'h0, 64'h0, 64'h0);
      put_beat(KIND_BLOCK, 4'hf, '1, '1);
      put_beat(KIND_BLOCK, 4'h5, 64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555);
      put_beat(KIND_BLOCK, 4'ha, 64'h0011223344556677, 64'h8899aabbccddeeff);

      // Swap the outermost keys between blocks.
      put_beat(KIND_KEY, 4'd0, '1, '1);
      put_beat(KIND_BLOCK, 4'h3, {$urandom, $urandom}, {$urandom, $urandom});
      put_beat(KIND_KEY, KR_MAX, 64'h0, 64'h0);
      put_beat(KIND_BLOCK, 4'hc, {$urandom, $urandom}, {$urandom, $urandom});

      queue_random(500);
      wait_drained();

      // Phase 2: heavy sender gaps, light receiver stalls.
      send_idle_pct  = 65;
      recv_stall_pct = 8;
      queue_random(500);
      wait_drained();

      // Phase 3: full rate on both sides.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random(500);
      wait_drained();

      // Let any stray result surface before deciding.
      repeat (DRAIN_TAIL) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/aesd_pkg.sv
design/aesd_round.sv
design/aes128_block_decrypt_top.sv
tb/sv/aes128_block_decrypt_top_tb.sv
